// File: rtl/csc_pkg.sv
`timescale 1ns / 1ps

package csc_pkg;

  // table geometry and field widths
  localparam int MAX_SLOTS    = 64;
  localparam int SLOT_BITS    = $clog2(MAX_SLOTS);
  localparam int COUNT_BITS   = $clog2(MAX_SLOTS + 1);
  localparam int BODY_ID_BITS = 16;
  localparam int DEPTH_BITS   = 32;
  localparam int OP_BITS      = 2;
  localparam int CAP_BITS     = 7;
  localparam int DROP_BITS    = 7;
  localparam logic [DROP_BITS-1:0] DROP_MAX = {DROP_BITS{1'b1}};

  // operation codes
  localparam logic [OP_BITS-1:0] OP_PREPARE = 2'd0;
  localparam logic [OP_BITS-1:0] OP_WRITE   = 2'd1;
  localparam logic [OP_BITS-1:0] OP_FINISH  = 2'd2;

  // one request
  typedef struct packed {
    logic [OP_BITS-1:0]            operation;
    logic [COUNT_BITS-1:0]         pair_count;
    logic [SLOT_BITS-1:0]          slot;
    logic                          entry_valid;
    logic [BODY_ID_BITS-1:0]       entry_body_a;
    logic [BODY_ID_BITS-1:0]       entry_body_b;
    logic signed [DEPTH_BITS-1:0]  entry_depth;
  } request_t;

  // one result
  typedef struct packed {
    logic [SLOT_BITS-1:0]          kept_slot;
    logic signed [DEPTH_BITS-1:0]  kept_depth;
    logic [BODY_ID_BITS-1:0]       kept_body_a;
    logic [BODY_ID_BITS-1:0]       kept_body_b;
    logic                          none_kept;
    logic                          last_result;
    logic [DROP_BITS-1:0]          dropped_total;
  } result_t;

  // one stored table entry
  typedef struct packed {
    logic [DEPTH_BITS-1:0]   depth;
    logic [BODY_ID_BITS-1:0] body_a;
    logic [BODY_ID_BITS-1:0] body_b;
  } entry_t;

  // candidate presented to the rank unit
  typedef struct packed {
    logic                 live;
    logic [SLOT_BITS-1:0] slot;
    entry_t               entry;
  } cand_t;

  // rank unit control
  typedef struct packed {
    logic clear;
    logic by_depth;
  } rank_ctl_t;

  // best entry found so far
  typedef struct packed {
    logic                 have;
    logic [SLOT_BITS-1:0] slot;
    entry_t               entry;
  } best_t;

endpackage

// File: rtl/contact_slot_compact_and_clamp_top.sv
`timescale 1ns / 1ps

// Contact slot table with compaction and a depth-ordered capacity clamp.
// Prepare, write and the unused operation code may follow each other every
// cycle; busy stays low for them. A finish holds busy high while it counts
// the valid slots, applies the clamp and then, for each kept contact, sweeps
// the entry table through one compare unit, waits for the registered table
// read and outputs the result; if nothing is kept it outputs a none-kept
// result. Results appear on result for one cycle each with result_valid high
// and cannot be stalled: the receiver must take every one. Once a finish has
// clamped, results come out deepest first with ties to the lower slot until
// the next prepare or valid write, otherwise in slot order.
// max_capacity may only be written while busy is low.
module contact_slot_compact_and_clamp_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  csc_pkg::request_t                   request,
  input  logic                                cfg_we,
  input  logic [csc_pkg::CAP_BITS-1:0]        cfg_wdata,
  output logic                                result_valid,
  output csc_pkg::result_t                    result
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_COUNT = 3'd1;
  localparam logic [2:0] S_CLAMP = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;
  localparam logic [2:0] S_NONE  = 3'd6;

  localparam logic [csc_pkg::SLOT_BITS-1:0] LAST_SLOT =
    csc_pkg::SLOT_BITS'(csc_pkg::MAX_SLOTS - 1);

  logic [2:0]                          state;
  logic [csc_pkg::CAP_BITS-1:0]        max_capacity;
  logic [csc_pkg::COUNT_BITS-1:0]      slots_in_use;
  logic [csc_pkg::DROP_BITS-1:0]       drop_counter;
  logic                                depth_order;
  logic [csc_pkg::MAX_SLOTS-1:0]       valid_marks;
  logic [csc_pkg::MAX_SLOTS-1:0]       taken;
  logic [csc_pkg::SLOT_BITS-1:0]       idx;
  logic [csc_pkg::COUNT_BITS-1:0]      n_count;
  logic [csc_pkg::COUNT_BITS-1:0]      limit;
  logic [csc_pkg::COUNT_BITS-1:0]      k;
  logic                                cand_live;
  logic [csc_pkg::SLOT_BITS-1:0]       cand_slot;

  logic                                accept;
  logic                                write_ok;
  logic [csc_pkg::COUNT_BITS-1:0]      prep_count;
  logic                                clamp_hit;
  logic [csc_pkg::COUNT_BITS-1:0]      limit_next;
  logic [csc_pkg::COUNT_BITS-1:0]      drops;
  logic [csc_pkg::DROP_BITS:0]         drop_sum;
  logic [csc_pkg::DROP_BITS-1:0]       drop_sat;
  logic [csc_pkg::MAX_SLOTS-1:0]       best_bit;
  logic [$bits(csc_pkg::entry_t)-1:0]  ram_rdata;
  csc_pkg::entry_t                     wr_entry;
  csc_pkg::cand_t                      cand;
  csc_pkg::rank_ctl_t                  rank_ctl;
  csc_pkg::best_t                      best;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // write qualification and prepare saturation
  assign write_ok = request.entry_valid
                 && (request.entry_body_a != request.entry_body_b)
                 && (csc_pkg::COUNT_BITS'(request.slot) < slots_in_use);
  assign prep_count = (request.pair_count > csc_pkg::COUNT_BITS'(csc_pkg::MAX_SLOTS))
                    ? csc_pkg::COUNT_BITS'(csc_pkg::MAX_SLOTS) : request.pair_count;

  // clamp decision and saturating drop total
  assign clamp_hit  = (max_capacity != '0) && (n_count > csc_pkg::COUNT_BITS'(max_capacity));
  assign limit_next = clamp_hit ? csc_pkg::COUNT_BITS'(max_capacity) : n_count;
  assign drops      = n_count - csc_pkg::COUNT_BITS'(max_capacity);
  assign drop_sum   = {1'b0, drop_counter} + (csc_pkg::DROP_BITS + 1)'(drops);
  assign drop_sat   = (drop_sum > (csc_pkg::DROP_BITS + 1)'(csc_pkg::DROP_MAX))
                    ? csc_pkg::DROP_MAX : drop_sum[csc_pkg::DROP_BITS-1:0];

  assign best_bit = csc_pkg::MAX_SLOTS'(1) << best.slot;

  // entry table
  assign wr_entry.depth  = request.entry_depth;
  assign wr_entry.body_a = request.entry_body_a;
  assign wr_entry.body_b = request.entry_body_b;

  csc_ram #(
    .WIDTH ($bits(csc_pkg::entry_t)),
    .DEPTH (csc_pkg::MAX_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (accept && (request.operation == csc_pkg::OP_WRITE) && write_ok),
    .waddr (request.slot),
    .wdata (wr_entry),
    .re    (state == S_SCAN),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // candidate lines up with the registered table read
  assign cand.live  = cand_live;
  assign cand.slot  = cand_slot;
  assign cand.entry = csc_pkg::entry_t'(ram_rdata);

  assign rank_ctl.clear    = (state == S_CLAMP) || (state == S_EMIT);
  assign rank_ctl.by_depth = depth_order;

  csc_rank_unit u_rank (
    .clk  (clk),
    .rst  (rst),
    .ctl  (rank_ctl),
    .cand (cand),
    .best (best)
  );

  // sequencer and table state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      max_capacity <= '0;
      slots_in_use <= '0;
      drop_counter <= '0;
      depth_order  <= 1'b0;
      valid_marks  <= '0;
      taken        <= '0;
      idx          <= '0;
      n_count      <= '0;
      limit        <= '0;
      k            <= '0;
      cand_live    <= 1'b0;
      cand_slot    <= '0;
    end else begin
      if (cfg_we) begin
        max_capacity <= cfg_wdata;
      end
      cand_live <= (state == S_SCAN) && valid_marks[idx] && !taken[idx];
      cand_slot <= idx;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (request.operation == csc_pkg::OP_PREPARE) begin
              slots_in_use <= prep_count;
              valid_marks  <= '0;
              drop_counter <= '0;
              depth_order  <= 1'b0;
            end else if (request.operation == csc_pkg::OP_WRITE) begin
              if (write_ok) begin
                valid_marks[request.slot] <= 1'b1;
                depth_order               <= 1'b0;
              end
            end else if (request.operation == csc_pkg::OP_FINISH) begin
              state   <= S_COUNT;
              idx     <= '0;
              n_count <= '0;
            end
          end
        end
        S_COUNT: begin
          n_count <= n_count + csc_pkg::COUNT_BITS'(valid_marks[idx]);
          idx     <= idx + 1'b1;
          if (idx == LAST_SLOT) begin
            state <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          if (clamp_hit) begin
            depth_order  <= 1'b1;
            drop_counter <= drop_sat;
          end
          limit <= limit_next;
          taken <= '0;
          k     <= '0;
          idx   <= '0;
          state <= (limit_next == '0) ? S_NONE : S_SCAN;
        end
        S_SCAN: begin
          idx <= idx + 1'b1;
          if (idx == LAST_SLOT) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          taken <= taken | best_bit;
          k     <= k + 1'b1;
          idx   <= '0;
          if (k == limit - 1'b1) begin
            // drop the marks of every entry that was not emitted
            valid_marks <= valid_marks & (taken | best_bit);
            state       <= S_IDLE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_NONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result drive
  always_comb begin
    result_valid         = (state == S_EMIT) || (state == S_NONE);
    result.dropped_total = drop_counter;
    if (state == S_EMIT) begin
      result.kept_slot   = best.slot;
      result.kept_depth  = best.entry.depth;
      result.kept_body_a = best.entry.body_a;
      result.kept_body_b = best.entry.body_b;
      result.none_kept   = 1'b0;
      result.last_result = (k == limit - 1'b1);
    end else begin
      result.kept_slot   = '0;
      result.kept_depth  = '0;
      result.kept_body_a = '0;
      result.kept_body_b = '0;
      result.none_kept   = (state == S_NONE);
      result.last_result = (state == S_NONE);
    end
  end

  // checks
  a_emit_has_best: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> best.have)
    else $error("emit without a selected entry");

  a_emit_not_taken: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> !taken[best.slot] && valid_marks[best.slot])
    else $error("selected entry already emitted or not valid");

  a_finish_goes_busy: assert property (@(posedge clk) disable iff (rst)
    accept && (request.operation == csc_pkg::OP_FINISH) |=> busy)
    else $error("finish request did not start the sweep");

  a_none_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.none_kept |-> result.last_result && (limit == '0))
    else $error("none kept result without empty list");

endmodule

// File: rtl/csc_ram.sv
`timescale 1ns / 1ps

module csc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/csc_rank_unit.sv
`timescale 1ns / 1ps

module csc_rank_unit (
  input  logic              clk,
  input  logic              rst,
  input  csc_pkg::rank_ctl_t ctl,
  input  csc_pkg::cand_t    cand,
  output csc_pkg::best_t    best
);

  logic take;

  // by depth, deeper wins and on a tie the earlier (lower) slot stays; else the first live one wins
  always_comb begin
    take = 1'b0;
    if (cand.live) begin
      if (!best.have) begin
        take = 1'b1;
      end else if (ctl.by_depth) begin
        take = $signed(cand.entry.depth) > $signed(best.entry.depth);
      end
    end
  end

  // best register
  always_ff @(posedge clk) begin
    if (rst) begin
      best.have <= 1'b0;
    end else if (ctl.clear) begin
      best.have <= 1'b0;
    end else if (take) begin
      best.have  <= 1'b1;
      best.slot  <= cand.slot;
      best.entry <= cand.entry;
    end
  end

endmodule

// File: test/kept_contact_monitor.sv
`timescale 1ns / 1ps

module kept_contact_monitor (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  csc_pkg::request_t            request,
  input  logic                         cfg_we,
  input  logic [csc_pkg::CAP_BITS-1:0] cfg_wdata,
  input  logic                         result_valid,
  input  csc_pkg::result_t             result,
  output int                           mismatches,
  output int                           outstanding
);

  // predicted slot table
  logic [csc_pkg::MAX_SLOTS-1:0]         marks = '0;
  logic signed [csc_pkg::DEPTH_BITS-1:0] depth_tab [csc_pkg::MAX_SLOTS];
  logic [csc_pkg::BODY_ID_BITS-1:0]      body_a_tab [csc_pkg::MAX_SLOTS];
  logic [csc_pkg::BODY_ID_BITS-1:0]      body_b_tab [csc_pkg::MAX_SLOTS];
  int unsigned                           slot_limit = 0;
  int unsigned                           drop_count = 0;
  int unsigned                           capacity = 0;
  bit                                    by_depth = 1'b0;

  // kept contacts the block still owes, oldest first
  csc_pkg::result_t kept_due [$];
  csc_pkg::result_t want;
  int               errs = 0;

  // deeper first, ties to the lower slot
  function automatic bit ranks_ahead(int a, int b);
    if (depth_tab[a] != depth_tab[b]) return depth_tab[a] > depth_tab[b];
    return a < b;
  endfunction

  // gather valid slots, clamp to capacity, queue the kept list
  task automatic predict_finish();
    int               order [$];
    int               n, keep, i, j, v;
    csc_pkg::result_t res;
    for (int s = 0; s < slot_limit; s++) begin
      if (marks[s]) order = {order, s};
    end
    n = order.size();
    keep = n;
    if (capacity != 0 && n > capacity) begin
      by_depth = 1'b1;
      keep = capacity;
      drop_count = (drop_count + n - capacity > csc_pkg::DROP_MAX) ? csc_pkg::DROP_MAX
                                                                   : drop_count + n - capacity;
    end
    if (by_depth) begin
      for (i = 1; i < n; i++) begin
        v = order[i];
        j = i;
        while (j > 0 && ranks_ahead(v, order[j-1])) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = v;
      end
      for (i = keep; i < n; i++) marks[order[i]] = 1'b0;
    end
    if (keep == 0) begin
      res = '0;
      res.none_kept = 1'b1;
      res.last_result = 1'b1;
      res.dropped_total = csc_pkg::DROP_BITS'(drop_count);
      kept_due = {kept_due, res};
    end else begin
      for (i = 0; i < keep; i++) begin
        res = '0;
        res.kept_slot = csc_pkg::SLOT_BITS'(order[i]);
        res.kept_depth = depth_tab[order[i]];
        res.kept_body_a = body_a_tab[order[i]];
        res.kept_body_b = body_b_tab[order[i]];
        res.last_result = (i == keep - 1);
        res.dropped_total = csc_pkg::DROP_BITS'(drop_count);
        kept_due = {kept_due, res};
      end
    end
  endtask

  // update the predicted table for one accepted request
  task automatic predict_request(input csc_pkg::request_t r);
    case (r.operation)
      csc_pkg::OP_PREPARE: begin
        slot_limit = (r.pair_count > csc_pkg::MAX_SLOTS) ? csc_pkg::MAX_SLOTS : r.pair_count;
        marks = '0;
        drop_count = 0;
        by_depth = 1'b0;
      end
      csc_pkg::OP_WRITE: begin
        if (r.entry_valid && r.entry_body_a != r.entry_body_b && r.slot < slot_limit) begin
          depth_tab[r.slot] = r.entry_depth;
          body_a_tab[r.slot] = r.entry_body_a;
          body_b_tab[r.slot] = r.entry_body_b;
          marks[r.slot] = 1'b1;
          by_depth = 1'b0;
        end
      end
      csc_pkg::OP_FINISH: predict_finish();
      default: ;
    endcase
  endtask

  task automatic compare_field(input string name,
                               input logic [csc_pkg::DEPTH_BITS-1:0] exp_val,
                               input logic [csc_pkg::DEPTH_BITS-1:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, got_val);
      errs++;
    end
  endtask

  // results first, then config, then the new request
  always @(posedge clk) begin
    if (rst) begin
      marks = '0;
      slot_limit = 0;
      drop_count = 0;
      capacity = 0;
      by_depth = 1'b0;
      kept_due.delete();
    end else begin
      if (result_valid) begin
        if (kept_due.size() == 0) begin
          $error("unexpected result: kept_slot %0d, none_kept %0b",
                 result.kept_slot, result.none_kept);
          errs++;
        end else begin
          want = kept_due.pop_front();
          compare_field("kept_slot", csc_pkg::DEPTH_BITS'(want.kept_slot),
                        csc_pkg::DEPTH_BITS'(result.kept_slot));
          compare_field("kept_depth", want.kept_depth, result.kept_depth);
          compare_field("kept_body_a", csc_pkg::DEPTH_BITS'(want.kept_body_a),
                        csc_pkg::DEPTH_BITS'(result.kept_body_a));
          compare_field("kept_body_b", csc_pkg::DEPTH_BITS'(want.kept_body_b),
                        csc_pkg::DEPTH_BITS'(result.kept_body_b));
          compare_field("none_kept", csc_pkg::DEPTH_BITS'(want.none_kept),
                        csc_pkg::DEPTH_BITS'(result.none_kept));
          compare_field("last_result", csc_pkg::DEPTH_BITS'(want.last_result),
                        csc_pkg::DEPTH_BITS'(result.last_result));
          compare_field("dropped_total", csc_pkg::DEPTH_BITS'(want.dropped_total),
                        csc_pkg::DEPTH_BITS'(result.dropped_total));
        end
      end
      if (cfg_we) capacity = cfg_wdata;
      if (start && !busy) predict_request(request);
    end
    mismatches <= errs;
    outstanding <= kept_due.size();
  end

endmodule

// File: test/contact_slot_compact_and_clamp_top_tb.sv
`timescale 1ns / 1ps

module contact_slot_compact_and_clamp_top_tb;

  localparam logic [csc_pkg::OP_BITS-1:0] OP_UNUSED = 2'd3;
  // worst case: every request a finish keeping 64 contacts, taken several times over
  localparam int CYCLE_LIMIT  = 6_000_000;
  localparam int RANDOM_ITEMS = 360;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic                         busy;
  csc_pkg::request_t            request = '0;
  logic                         cfg_we = 1'b0;
  logic [csc_pkg::CAP_BITS-1:0] cfg_wdata = '0;
  logic                         result_valid;
  csc_pkg::result_t             result;
  int                           mismatches;
  int                           outstanding;
  int                           cycles = 0;
  int                           burst_left = 0;
  int                           fed = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  contact_slot_compact_and_clamp_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .result_valid (result_valid),
    .result       (result)
  );

  kept_contact_monitor u_monitor (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .result_valid (result_valid),
    .result       (result),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // request with every field random except the operation
  function automatic csc_pkg::request_t blank_request(input logic [csc_pkg::OP_BITS-1:0] op);
    csc_pkg::request_t r;
    r.operation = op;
    r.pair_count = csc_pkg::COUNT_BITS'($urandom);
    r.slot = csc_pkg::SLOT_BITS'($urandom);
    r.entry_valid = 1'($urandom);
    r.entry_body_a = csc_pkg::BODY_ID_BITS'($urandom);
    r.entry_body_b = csc_pkg::BODY_ID_BITS'($urandom);
    r.entry_depth = csc_pkg::DEPTH_BITS'($urandom);
    return r;
  endfunction

  // depths biased toward ties and extremes
  function automatic logic signed [csc_pkg::DEPTH_BITS-1:0] pick_depth();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return csc_pkg::DEPTH_BITS'($urandom);
      4: return {csc_pkg::DEPTH_BITS{1'b1}};
      5: return 32'sh7FFF_FFFF;
      6: return 32'sh8000_0000;
      default: return csc_pkg::DEPTH_BITS'($urandom_range(0, 3)) << 16;
    endcase
  endfunction

  // send one request in bursts with random gaps
  task automatic issue(input csc_pkg::request_t r);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(24, 64)
                                               : $urandom_range(1, 8);
    end
    start <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    burst_left--;
    fed++;
  endtask

  // capacity changes only once the block has gone quiet
  task automatic set_capacity(input int unsigned value);
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= csc_pkg::CAP_BITS'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic prepare_slots(input int count);
    csc_pkg::request_t r;
    r = blank_request(csc_pkg::OP_PREPARE);
    r.pair_count = csc_pkg::COUNT_BITS'(count);
    issue(r);
  endtask

  task automatic write_slot(input int slot, input bit valid,
                            input logic [csc_pkg::BODY_ID_BITS-1:0] a,
                            input logic [csc_pkg::BODY_ID_BITS-1:0] b,
                            input logic signed [csc_pkg::DEPTH_BITS-1:0] depth);
    csc_pkg::request_t r;
    r = blank_request(csc_pkg::OP_WRITE);
    r.slot = csc_pkg::SLOT_BITS'(slot);
    r.entry_valid = valid;
    r.entry_body_a = a;
    r.entry_body_b = b;
    r.entry_depth = depth;
    issue(r);
  endtask

  task automatic finish_pass();
    issue(blank_request(csc_pkg::OP_FINISH));
  endtask

  // prepare, a mix of good and broken writes, then one or more finishes
  task automatic run_scenario();
    int count, span, writes, s;
    logic [csc_pkg::BODY_ID_BITS-1:0] a;
    case ($urandom_range(0, 9))
      0: count = $urandom_range(0, 127);
      1: count = csc_pkg::MAX_SLOTS;
      default: count = $urandom_range(1, 16);
    endcase
    span = (count > csc_pkg::MAX_SLOTS) ? csc_pkg::MAX_SLOTS : count;
    prepare_slots(count);
    writes = $urandom_range(0, (span < 20) ? span + 4 : 24);
    repeat (writes) begin
      s = (span == 0) ? $urandom_range(0, 63) : $urandom_range(0, span - 1);
      a = csc_pkg::BODY_ID_BITS'($urandom);
      case ($urandom_range(0, 11))
        0: write_slot(s, 1'b0, a, ~a, pick_depth());
        1: write_slot(s, 1'b1, a, a, pick_depth());
        2: write_slot((span < csc_pkg::MAX_SLOTS) ? $urandom_range(span, 63) : s, 1'b1, a, ~a,
                      pick_depth());
        3: issue(blank_request(OP_UNUSED));
        default: begin
          write_slot(s, 1'b1, a, a ^ csc_pkg::BODY_ID_BITS'($urandom_range(1, 65535)),
                     pick_depth());
        end
      endcase
    end
    finish_pass();
    case ($urandom_range(0, 3))
      0: begin
        finish_pass();
      end
      1: begin
        repeat ($urandom_range(1, 4)) begin
          a = csc_pkg::BODY_ID_BITS'($urandom);
          write_slot((span == 0) ? 0 : $urandom_range(0, span - 1), 1'b1, a, ~a, pick_depth());
        end
        finish_pass();
      end
      default: ;
    endcase
  endtask

  initial begin
    int round, s;
    logic [csc_pkg::BODY_ID_BITS-1:0] a;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    set_capacity(0);

    // finish straight out of reset keeps nothing
    finish_pass();
    issue(blank_request(OP_UNUSED));
    // oversized slot count saturates, extreme ids and depths, ignored writes, depth ties
    prepare_slots(127);
    write_slot(63, 1'b1, 16'hFFFF, 16'h0000, 32'sh7FFF_FFFF);
    write_slot(0, 1'b1, 16'h0000, 16'hFFFF, 32'sh8000_0000);
    write_slot(5, 1'b0, 16'h0011, 16'h0022, 32'sh0001_0000);
    write_slot(6, 1'b1, 16'h1234, 16'h1234, 32'sh0001_0000);
    write_slot(1, 1'b1, 16'h0001, 16'h0002, 32'sh0000_0000);
    write_slot(2, 1'b1, 16'h0003, 16'h0004, 32'sh0000_0000);
    finish_pass();
    // clamp, repeat finish, then a write drops back to slot order
    set_capacity(2);
    finish_pass();
    finish_pass();
    write_slot(3, 1'b1, 16'h0005, 16'h0006, 32'sh0000_0005);
    finish_pass();
    // writes at or above the slot count are ignored
    prepare_slots(4);
    write_slot(5, 1'b1, 16'h0007, 16'h0008, 32'sh0000_0001);
    write_slot(3, 1'b1, 16'h0009, 16'h000A, 32'sh0000_0001);
    finish_pass();
    set_capacity(64);
    prepare_slots(0);
    write_slot(0, 1'b1, 16'h000B, 16'h000C, 32'sh0000_0001);
    finish_pass();

    // refill a full table twice, then eight slots, under capacity one so the drop total saturates
    set_capacity(1);
    prepare_slots(csc_pkg::MAX_SLOTS);
    for (round = 0; round < 3; round++) begin
      for (s = 0; s < ((round < 2) ? csc_pkg::MAX_SLOTS : 8); s++) begin
        a = csc_pkg::BODY_ID_BITS'($urandom);
        write_slot(s, 1'b1, a, a ^ csc_pkg::BODY_ID_BITS'($urandom_range(1, 65535)),
                   pick_depth());
      end
      finish_pass();
    end

    // random phases, capacity changed now and then
    while (fed < RANDOM_ITEMS) begin
      case ($urandom_range(0, 11))
        0: set_capacity(0);
        1: set_capacity(1);
        2: set_capacity(64);
        3: set_capacity($urandom_range(0, 64));
        4, 5: set_capacity($urandom_range(1, 6));
        default: ;
      endcase
      run_scenario();
    end

    // drain outstanding results
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || busy) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/csc_pkg.sv
rtl/csc_ram.sv
rtl/csc_rank_unit.sv
rtl/contact_slot_compact_and_clamp_top.sv
test/kept_contact_monitor.sv
test/contact_slot_compact_and_clamp_top_tb.sv
